// ----- hw/rtl/lswc_pkg.sv -----
package lswc_pkg;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int DIV_STEPS   = PROD_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int MUL_LO_W    = (DIFF_W + 1) / 2;
  localparam int MUL_HI_W    = DIFF_W - MUL_LO_W;
  localparam int QCLAMP_W    = COORD_W + 2;
  localparam int SUM_W       = QCLAMP_W + 2;
  localparam int SLIDE_LIMIT = 4;
  localparam int SLIDE_CNT_W = 3;
  localparam int CFG_IDX_W   = 2;

  // outcode bit positions
  localparam int CODE_LEFT  = 0;
  localparam int CODE_RIGHT = 1;
  localparam int CODE_BELOW = 2;
  localparam int CODE_ABOVE = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

  typedef logic [3:0] outcode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [COORD_W-1:0] clipped_start_x;
    logic signed [COORD_W-1:0] clipped_start_y;
    logic signed [COORD_W-1:0] clipped_end_x;
    logic signed [COORD_W-1:0] clipped_end_y;
  } seg_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic all_inside;
    logic share_side;
    logic out_full;
  } status_t;

endpackage

// ----- hw/rtl/lswc_ctrl.sv -----
module lswc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lswc_pkg::status_t  status,
  output lswc_pkg::cmd_t     cmd
);

  lswc_pkg::state_t state, state_next;
  logic [lswc_pkg::SLIDE_CNT_W-1:0] slide_cnt, slide_cnt_next;
  logic [lswc_pkg::DIV_CNT_W-1:0]   div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lswc_pkg::ST_IDLE;
      slide_cnt <= '0;
      div_cnt   <= '0;
    end else begin
      state     <= state_next;
      slide_cnt <= slide_cnt_next;
      div_cnt   <= div_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    slide_cnt_next = slide_cnt;
    div_cnt_next   = div_cnt;
    cmd            = '0;
    in_stall       = 1'b1;
    case (state)
      lswc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load       = 1'b1;
          slide_cnt_next = '0;
          state_next     = lswc_pkg::ST_TEST;
        end
      end
      lswc_pkg::ST_TEST: begin
        if (status.all_inside || status.share_side ||
            slide_cnt == lswc_pkg::SLIDE_CNT_W'(lswc_pkg::SLIDE_LIMIT)) begin
          state_next = lswc_pkg::ST_FINISH;
        end else begin
          cmd.setup  = 1'b1;
          state_next = lswc_pkg::ST_MUL_LO;
        end
      end
      lswc_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = lswc_pkg::ST_MUL_HI;
      end
      lswc_pkg::ST_MUL_HI: begin
        cmd.mul_hi   = 1'b1;
        div_cnt_next = '0;
        state_next   = lswc_pkg::ST_DIV;
      end
      lswc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == lswc_pkg::DIV_CNT_W'(lswc_pkg::DIV_STEPS - 1)) begin
          state_next = lswc_pkg::ST_UPDATE;
        end
      end
      lswc_pkg::ST_UPDATE: begin
        cmd.update     = 1'b1;
        slide_cnt_next = slide_cnt + 1'b1;
        state_next     = lswc_pkg::ST_TEST;
      end
      lswc_pkg::ST_FINISH: begin
        // hold the result until the output register is free
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = lswc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lswc_pkg::ST_IDLE;
      end
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_full)
    else $error("result loaded over a pending transaction");

  a_slide_bound: assert property (@(posedge clk) disable iff (rst)
    slide_cnt <= lswc_pkg::SLIDE_CNT_W'(lswc_pkg::SLIDE_LIMIT))
    else $error("slide count beyond limit");

  a_accept_tests: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == lswc_pkg::ST_TEST)
    else $error("accepted transaction not tested next");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == lswc_pkg::ST_UPDATE) |-> $past(state) == lswc_pkg::ST_DIV)
    else $error("update without divide");

endmodule

// ----- hw/rtl/lswc_datapath.sv -----
module lswc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lswc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lswc_pkg::COORD_W-1:0]        cfg_data,
  input  lswc_pkg::seg_in_t                   in_data,
  input  lswc_pkg::cmd_t                      cmd,
  output lswc_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lswc_pkg::seg_out_t                  out_data
);

  localparam int W  = lswc_pkg::COORD_W;
  localparam int D  = lswc_pkg::DIFF_W;
  localparam int P  = lswc_pkg::PROD_W;
  localparam int LO = lswc_pkg::MUL_LO_W;
  localparam int HI = lswc_pkg::MUL_HI_W;
  localparam int QW = lswc_pkg::QCLAMP_W;
  localparam int SW = lswc_pkg::SUM_W;

  function automatic lswc_pkg::outcode_t code_of(
    input logic signed [W-1:0] x, input logic signed [W-1:0] y,
    input logic signed [W-1:0] xl, input logic signed [W-1:0] yl,
    input logic signed [W-1:0] xh, input logic signed [W-1:0] yh);
    lswc_pkg::outcode_t c;
    c = '0;
    if (x < xl) c[lswc_pkg::CODE_LEFT] = 1'b1;
    else if (x > xh) c[lswc_pkg::CODE_RIGHT] = 1'b1;
    if (y < yl) c[lswc_pkg::CODE_BELOW] = 1'b1;
    else if (y > yh) c[lswc_pkg::CODE_ABOVE] = 1'b1;
    return c;
  endfunction

  function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
    return v[D-1] ? D'(-v) : D'(v);
  endfunction

  logic signed [W-1:0] win_x_min, win_y_min, win_x_max, win_y_max;
  logic signed [W-1:0] x1, y1, x2, y2;

  // slide operands
  logic                side1, y_edge, neg, zero_div;
  logic signed [W-1:0] edge_val, base;
  logic [D-1:0]        mag_a, mag_b, div_d;
  logic [P-1:0]        acc, dvd;
  logic [D-1:0]        rem;

  lswc_pkg::outcode_t c1, c2, pick;

  always_comb begin
    c1 = code_of(x1, y1, win_x_min, win_y_min, win_x_max, win_y_max);
    c2 = code_of(x2, y2, win_x_min, win_y_min, win_x_max, win_y_max);
    pick = (c1 != '0) ? c1 : c2;
    status.all_inside = ((c1 | c2) == '0);
    status.share_side = ((c1 & c2) != '0);
    status.out_full   = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x_min <= '0;
      win_y_min <= '0;
      win_x_max <= '0;
      win_y_max <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lswc_pkg::REG_X_MIN: win_x_min <= cfg_data;
        lswc_pkg::REG_Y_MIN: win_y_min <= cfg_data;
        lswc_pkg::REG_X_MAX: win_x_max <= cfg_data;
        lswc_pkg::REG_Y_MAX: win_y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // setup operands
  logic                s_yedge;
  logic signed [W-1:0] s_edge, s_base;
  logic signed [D-1:0] s_span, s_part, s_whole;

  always_comb begin
    s_yedge = pick[lswc_pkg::CODE_ABOVE] || pick[lswc_pkg::CODE_BELOW];
    if (s_yedge) begin
      s_edge  = pick[lswc_pkg::CODE_ABOVE] ? win_y_max : win_y_min;
      s_base  = x1;
      s_span  = {x2[W-1], x2} - {x1[W-1], x1};
      s_part  = {s_edge[W-1], s_edge} - {y1[W-1], y1};
      s_whole = {y2[W-1], y2} - {y1[W-1], y1};
    end else begin
      s_edge  = pick[lswc_pkg::CODE_RIGHT] ? win_x_max : win_x_min;
      s_base  = y1;
      s_span  = {y2[W-1], y2} - {y1[W-1], y1};
      s_part  = {s_edge[W-1], s_edge} - {x1[W-1], x1};
      s_whole = {x2[W-1], x2} - {x1[W-1], x1};
    end
  end

  // one shared multiplier, operand b taken in two halves
  logic [LO-1:0]   b_sel;
  logic [D+LO-1:0] pp;

  always_comb begin
    b_sel = cmd.mul_hi ? LO'(mag_b[D-1:LO]) : mag_b[LO-1:0];
    pp    = mag_a * b_sel;
  end

  // two restoring quotient bits per cycle
  logic [D:0]   r1, r1s, r2, r2s;
  logic         ge1, ge2;

  always_comb begin
    r1  = {rem, dvd[P-1]};
    ge1 = r1 >= {1'b0, div_d};
    r1s = ge1 ? r1 - {1'b0, div_d} : r1;
    r2  = {r1s[D-1:0], dvd[P-2]};
    ge2 = r2 >= {1'b0, div_d};
    r2s = ge2 ? r2 - {1'b0, div_d} : r2;
  end

  // clamp quotient, add to base and saturate
  logic [QW-1:0]        qc;
  logic signed [SW-1:0] sum;
  logic signed [W-1:0]  interp;

  always_comb begin
    if (dvd[P-1:QW-1] != '0) qc = QW'(1) << (QW - 1);
    else qc = dvd[QW-1:0];
    sum = SW'(base) + (neg ? -SW'({1'b0, qc}) : SW'({1'b0, qc}));
    if (zero_div) interp = base;
    else if (sum > SW'($signed({1'b0, {(W-1){1'b1}}}))) interp = {1'b0, {(W-1){1'b1}}};
    else if (sum < SW'($signed({1'b1, {(W-1){1'b0}}}))) interp = {1'b1, {(W-1){1'b0}}};
    else interp = sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= in_data.start_x;
      y1 <= in_data.start_y;
      x2 <= in_data.end_x;
      y2 <= in_data.end_y;
    end else if (cmd.update) begin
      if (side1) begin
        x1 <= y_edge ? interp : edge_val;
        y1 <= y_edge ? edge_val : interp;
      end else begin
        x2 <= y_edge ? interp : edge_val;
        y2 <= y_edge ? edge_val : interp;
      end
    end
    if (cmd.setup) begin
      side1    <= (c1 != '0);
      y_edge   <= s_yedge;
      edge_val <= s_edge;
      base     <= s_base;
      mag_a    <= mag(s_span);
      mag_b    <= mag(s_part);
      div_d    <= mag(s_whole);
      neg      <= s_span[D-1] ^ s_part[D-1] ^ s_whole[D-1];
      zero_div <= (s_whole == '0);
    end
    if (cmd.mul_lo) acc <= P'(pp);
    if (cmd.mul_hi) begin
      dvd <= acc + (P'(pp) << LO);
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[P-3:0], ge1, ge2};
      rem <= r2s[D-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.accepted        <= status.all_inside;
      out_data.clipped_start_x <= status.all_inside ? x1 : '0;
      out_data.clipped_start_y <= status.all_inside ? y1 : '0;
      out_data.clipped_end_x   <= status.all_inside ? x2 : '0;
      out_data.clipped_end_y   <= status.all_inside ? y2 : '0;
    end
  end

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled transaction changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.accepted) |->
      (out_data.clipped_start_x == '0 && out_data.clipped_end_y == '0))
    else $error("rejected transaction carries coordinates");

  a_kept_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && status.all_inside |-> !status.share_side)
    else $error("outcode status inconsistent");

endmodule

// ----- hw/rtl/line_segment_window_clipper_core.sv -----
// Sequence: a segment needing no slide is tested and finished before out_valid rises; each slide
// adds two multiply steps, the divide steps at two quotient bits per cycle, the update and a
// retest, and at most 4 slides are made.
// Flow control: one segment at a time; the serial divider sets the rate, and a stalled result
// holds the following segment in its finish state until the output register is free.
// Reset (rst, synchronous): window registers cleared to zero, controller idle, no result.
module line_segment_window_clipper_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lswc_pkg::seg_in_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lswc_pkg::seg_out_t                 out_data,
  input  logic                               cfg_we,
  input  logic [lswc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lswc_pkg::COORD_W-1:0]       cfg_data
);

  lswc_pkg::cmd_t    cmd;
  lswc_pkg::status_t status;

  lswc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lswc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- verif/line_segment_window_clipper_core_checker.sv -----
`timescale 1ns / 100ps
module line_segment_window_clipper_core_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  lswc_pkg::seg_in_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  lswc_pkg::seg_out_t             out_data,
  input  logic                           cfg_we,
  input  logic [lswc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lswc_pkg::COORD_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             pending
);

  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;

  longint win_x_min, win_y_min, win_x_max, win_y_max;
  lswc_pkg::seg_out_t clip_queue[$];

  assign pending = clip_queue.size();

  function automatic logic [3:0] region(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_x_min) c[lswc_pkg::CODE_LEFT] = 1'b1;
    else if (x > win_x_max) c[lswc_pkg::CODE_RIGHT] = 1'b1;
    if (y < win_y_min) c[lswc_pkg::CODE_BELOW] = 1'b1;
    else if (y > win_y_max) c[lswc_pkg::CODE_ABOVE] = 1'b1;
    return c;
  endfunction

  // base + span * part / whole, truncate toward zero, limit quotient to 2^62, saturate
  function automatic longint lerp(longint base, longint span, longint part, longint whole);
    logic signed [127:0] prod, quot, lim;
    logic signed [127:0] r;
    if (whole == 0) return base;
    lim = 128'sd1 <<< 62;
    prod = 128'(span) * 128'(part);
    quot = prod / 128'(whole);
    if (quot > lim) quot = lim;
    if (quot < -lim) quot = -lim;
    r = 128'(base) + quot;
    if (r > COORD_HI) r = COORD_HI;
    if (r < COORD_LO) r = COORD_LO;
    return longint'(r);
  endfunction

  function automatic lswc_pkg::seg_out_t clip_segment(lswc_pkg::seg_in_t s);
    longint x1, y1, x2, y2, nx, ny;
    logic [3:0] c1, c2, pick;
    logic keep;
    lswc_pkg::seg_out_t r;
    x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
    c1 = region(x1, y1);
    c2 = region(x2, y2);
    keep = 1'b0;
    for (int n = 0; n <= lswc_pkg::SLIDE_LIMIT; n++) begin
      if ((c1 | c2) == 0) begin
        keep = 1'b1;
        break;
      end
      if ((c1 & c2) != 0) break;
      if (n == lswc_pkg::SLIDE_LIMIT) break;
      pick = (c1 != 0) ? c1 : c2;
      if (pick[lswc_pkg::CODE_ABOVE]) begin
        ny = win_y_max;
        nx = lerp(x1, x2 - x1, win_y_max - y1, y2 - y1);
      end else if (pick[lswc_pkg::CODE_BELOW]) begin
        ny = win_y_min;
        nx = lerp(x1, x2 - x1, win_y_min - y1, y2 - y1);
      end else if (pick[lswc_pkg::CODE_RIGHT]) begin
        nx = win_x_max;
        ny = lerp(y1, y2 - y1, win_x_max - x1, x2 - x1);
      end else begin
        nx = win_x_min;
        ny = lerp(y1, y2 - y1, win_x_min - x1, x2 - x1);
      end
      if (c1 != 0) begin
        x1 = nx; y1 = ny; c1 = region(x1, y1);
      end else begin
        x2 = nx; y2 = ny; c2 = region(x2, y2);
      end
    end
    r = '0;
    r.accepted = keep;
    if (keep) begin
      r.clipped_start_x = x1[lswc_pkg::COORD_W-1:0];
      r.clipped_start_y = y1[lswc_pkg::COORD_W-1:0];
      r.clipped_end_x   = x2[lswc_pkg::COORD_W-1:0];
      r.clipped_end_y   = y2[lswc_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    lswc_pkg::seg_out_t want;
    if (rst) begin
      win_x_min <= 0; win_y_min <= 0; win_x_max <= 0; win_y_max <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lswc_pkg::REG_X_MIN: win_x_min <= longint'($signed(cfg_data));
          lswc_pkg::REG_Y_MIN: win_y_min <= longint'($signed(cfg_data));
          lswc_pkg::REG_X_MAX: win_x_max <= longint'($signed(cfg_data));
          lswc_pkg::REG_Y_MAX: win_y_max <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) clip_queue.push_back(clip_segment(in_data));
      if (out_valid && !out_stall) begin
        if (clip_queue.size() == 0) begin
          report("unexpected transaction, accepted", out_data.accepted, 0);
        end else begin
          want = clip_queue.pop_front();
          if (out_data.accepted != want.accepted)
            report("accepted", out_data.accepted, want.accepted);
          if (out_data.clipped_start_x != want.clipped_start_x)
            report("clipped_start_x", out_data.clipped_start_x, want.clipped_start_x);
          if (out_data.clipped_start_y != want.clipped_start_y)
            report("clipped_start_y", out_data.clipped_start_y, want.clipped_start_y);
          if (out_data.clipped_end_x != want.clipped_end_x)
            report("clipped_end_x", out_data.clipped_end_x, want.clipped_end_x);
          if (out_data.clipped_end_y != want.clipped_end_y)
            report("clipped_end_y", out_data.clipped_end_y, want.clipped_end_y);
        end
      end
    end
  end

endmodule

// ----- verif/line_segment_window_clipper_core_tb.sv -----
`timescale 1ns / 100ps
module line_segment_window_clipper_core_tb;

  localparam int CYCLE_LIMIT = 1500000;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  lswc_pkg::seg_in_t              in_data;
  logic                           out_valid;
  logic                           out_stall;
  lswc_pkg::seg_out_t             out_data;
  logic                           cfg_we;
  logic [lswc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lswc_pkg::COORD_W-1:0]   cfg_data;
  int                             mismatches;
  int                             pending;
  int                             cycles;
  logic                           hold_off;
  logic                           sending;

  line_segment_window_clipper_core dut (.*);

  line_segment_window_clipper_core_checker checker_i (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off while segments keep coming
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (sending);
    repeat (200) @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic write_reg(logic [lswc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(logic [31:0] xl, logic [31:0] yl, logic [31:0] xh,
                            logic [31:0] yh);
    write_reg(lswc_pkg::REG_X_MIN, xl);
    write_reg(lswc_pkg::REG_Y_MIN, yl);
    write_reg(lswc_pkg::REG_X_MAX, xh);
    write_reg(lswc_pkg::REG_Y_MAX, yh);
  endtask

  task automatic send(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{start_x: sx, start_y: sy, end_x: ex, end_y: ey};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(int count, int mode);
    for (int i = 0; i < count; i++)
      send(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode));
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sending = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window is a single point
    send(0, 0, 0, 0);
    send(32'hffff0000, 0, 32'h10000, 0);
    drain();

    set_window(32'hfff60000, 32'hfff60000, 32'h000a0000, 32'h000a0000);
    send(0, 0, 32'h10000, 32'h10000);                         // inside
    send(32'hffe20000, 0, 32'h001e0000, 0);                   // crosses the left and right sides
    send(0, 32'hffe20000, 0, 32'h001e0000);                   // crosses the lower and upper sides
    send(32'hffe20000, 32'hffe20000, 32'h001e0000, 32'h001e0000); // diagonal
    send(32'hffe20000, 0, 32'hffe20000, 32'h50000);           // shared left: reject
    send(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send(32'h7fffffff, 0, 32'h80000000, 32'h1);
    send(32'h001e0000, 32'h00050000, 32'h00050000, 32'h001e0000); // corner miss
    send(32'hfff60000, 32'hfff60000, 32'h000a0000, 32'h000a0000); // on edges
    drain();

    // inverted window: zero divisors and slide limit
    set_window(32'h000a0000, 32'h000a0000, 32'hfff60000, 32'hfff60000);
    send(0, 0, 32'h10000, 32'h10000);
    send(0, 0, 0, 32'h10000);
    send(32'hffe20000, 0, 32'h001e0000, 32'h10);
    random_phase(20, 0);
    drain();

    set_window(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    random_phase(20, 1);
    drain();

    set_window(32'hfff60000, 32'hfff80000, 32'h000a0000, 32'h00080000);
    sending = 1'b1;
    random_phase(250, 0);
    random_phase(60, 1);
    random_phase(30, 2);
    drain();

    set_window($urandom, $urandom, $urandom, $urandom);
    random_phase(40, 1);
    drain();

    set_window(32'h7fff0000, 32'h80000000, 32'h7fffffff, 32'h80010000);
    random_phase(40, 2);
    random_phase(40, 1);
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
